[hw/rtl/rskg_pkg.sv]
// Package with shared types and constants of the sort key generator.
package rskg_pkg;

  // Configuration register indexes.
  localparam logic [2:0] RegSortMode = 3'd0;
  localparam logic [2:0] RegCameraX  = 3'd1;
  localparam logic [2:0] RegCameraY  = 3'd2;
  localparam logic [2:0] RegCameraZ  = 3'd3;
  localparam logic [2:0] RegFarPlane = 3'd4;

  // Sort modes.
  localparam logic [1:0] ModeTypeKeyDist = 2'd0;
  localparam logic [1:0] ModeBackToFront = 2'd1;
  localparam logic [1:0] ModeDepthOnly   = 2'd2;
  localparam logic [1:0] ModeKeyOnly     = 2'd3;

  // Pipeline geometry.
  localparam int unsigned SqrtBits = 34;   // root bits, one cell per bit
  localparam int unsigned SqBits   = 68;   // width of the sum of squares
  localparam int unsigned DivBits  = 32;   // quotient bits, one cell per bit

  // Item payload as it enters.
  typedef struct packed {
    logic [31:0]        type_hash;
    logic signed [31:0] object_x;
    logic signed [31:0] object_y;
    logic signed [31:0] object_z;
    logic signed [31:0] depth_offset;
    logic [31:0]        item_key;
  } item_t;

  // Context travelling with an item through the cells.
  typedef struct packed {
    logic [15:0]        h16;
    logic [31:0]        item_key;
    logic signed [31:0] depth_offset;
    logic [1:0]         mode;
    logic [30:0]        far;
  } ctx_t;

  // State handed from one square-root cell to the next.
  typedef struct packed {
    logic              vld;
    logic [SqBits-1:0] rem;   // radicand minus root squared
    logic [SqrtBits-1:0] root;
    ctx_t              ctx;
  } sqrt_t;

  // State handed from one divider cell to the next.
  typedef struct packed {
    logic        vld;
    logic [31:0] rem;       // partial remainder, below far
    logic [63:0] num;       // numerator bits still to shift in, msb first
    logic [31:0] quo;
    logic [1:0]  sat;       // 0 divide, 1 zero, 2 saturate
    ctx_t        ctx;
  } div_t;

  localparam logic [1:0] SatNone = 2'd0;
  localparam logic [1:0] SatZero = 2'd1;
  localparam logic [1:0] SatMax  = 2'd2;

endpackage

[hw/rtl/rskg_if.sv]
// Valid/ready channel interfaces of the sort key generator.
interface rskg_item_if;
  logic                 valid;
  logic                 ready;
  rskg_pkg::item_t      data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rskg_key_if;
  logic        valid;
  logic        ready;
  logic [63:0] sort_key;
  modport source (output valid, output sort_key, input ready);
  modport sink   (input valid, input sort_key, output ready);
endinterface

interface rskg_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

[hw/rtl/rskg_sqrt_cell.sv]
// One restoring square-root cell: settles one root bit per item.
module rskg_sqrt_cell #(
  parameter int unsigned Bit = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  rskg_pkg::sqrt_t in_i,
  output rskg_pkg::sqrt_t out_o
);
  localparam int unsigned W = rskg_pkg::SqBits;

  logic [W-1:0] trial;
  logic [W-1:0] root_w;
  logic         vld_q;
  rskg_pkg::sqrt_t cell_d, cell_q;

  // (2r + 2^b) * 2^b is what trying bit b adds to root squared.
  always_comb begin
    root_w = W'(in_i.root);
    trial  = (root_w << (Bit + 1)) + (W'(1) << (2 * Bit));
    cell_d = in_i;
    if (in_i.rem >= trial) begin
      cell_d.rem  = in_i.rem - trial;
      cell_d.root = in_i.root | (rskg_pkg::SqrtBits'(1) << Bit);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= cell_d.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  // The valid bit comes from the reset register, the payload from the data register.
  always_comb begin
    out_o     = cell_q;
    out_o.vld = vld_q;
  end
endmodule

[hw/rtl/rskg_div_cell.sv]
// One restoring divider cell: settles one quotient bit per item.
module rskg_div_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  rskg_pkg::div_t in_i,
  output rskg_pkg::div_t out_o
);
  logic [32:0] shifted;
  logic [32:0] diff;
  logic        vld_q;
  rskg_pkg::div_t cell_d, cell_q;

  // Shift in the next numerator bit and subtract the far plane if it fits.
  always_comb begin
    shifted = {in_i.rem, in_i.num[63]};
    diff    = shifted - {2'b00, in_i.ctx.far};
    cell_d  = in_i;
    cell_d.num = {in_i.num[62:0], 1'b0};
    if (!diff[32]) begin
      cell_d.rem = diff[31:0];
      cell_d.quo = {in_i.quo[30:0], 1'b1};
    end else begin
      cell_d.rem = shifted[31:0];
      cell_d.quo = {in_i.quo[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= cell_d.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  // The valid bit comes from the reset register, the payload from the data register.
  always_comb begin
    out_o     = cell_q;
    out_o.vld = vld_q;
  end
endmodule

[hw/rtl/render_sort_key_generator_top.sv]
// Path: difference and square registers, root cells, numerator register, divider cells, output register.
// Throughput: one item per cycle unless the output stalls; all root and divider cells advance together.
// A stalled output holds the whole chain; ready returns as soon as the output is taken.
// Reset clears all valid bits; registers reset to mode 0, camera at origin, far plane 1.0.
// Configuration is taken at any time and applies to items accepted after the write.
module render_sort_key_generator_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  rskg_cfg_if.sink    cfg,
  rskg_item_if.sink   item,
  rskg_key_if.source  key
);
  localparam int unsigned SB = rskg_pkg::SqrtBits;
  localparam int unsigned QW = rskg_pkg::SqBits;
  localparam logic [30:0] FarReset = 31'(64'd1 << FRAC_BITS);

  // Configuration registers.
  logic [1:0]         mode_q;
  logic signed [31:0] cam_x_q, cam_y_q, cam_z_q;
  logic [30:0]        far_q;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= rskg_pkg::ModeTypeKeyDist;
      cam_x_q <= '0;
      cam_y_q <= '0;
      cam_z_q <= '0;
      far_q   <= FarReset;
    end else if (cfg.valid) begin
      case (cfg.index)
        rskg_pkg::RegSortMode: mode_q  <= cfg.wdata[1:0];
        rskg_pkg::RegCameraX:  cam_x_q <= cfg.wdata;
        rskg_pkg::RegCameraY:  cam_y_q <= cfg.wdata;
        rskg_pkg::RegCameraZ:  cam_z_q <= cfg.wdata;
        rskg_pkg::RegFarPlane: far_q   <= cfg.wdata[30:0];
        default: ;
      endcase
    end
  end

  // The whole chain moves when the output register is free.
  logic adv;
  logic out_vld_q;
  logic [63:0] out_key_q;
  assign adv        = !out_vld_q || key.ready;
  assign item.ready = adv;

  // Stage 1: differences.
  logic        s1_vld_q;
  logic [32:0] s1_dx_q, s1_dy_q, s1_dz_q;
  rskg_pkg::ctx_t s1_ctx_q;
  logic signed [32:0] dx, dy, dz;
  always_comb begin
    dx = 33'(cam_x_q) - 33'(item.data.object_x);
    dy = 33'(cam_y_q) - 33'(item.data.object_y);
    dz = 33'(cam_z_q) - 33'(item.data.object_z);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_vld_q <= 1'b0;
    else if (adv) s1_vld_q <= item.valid;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_dx_q <= dx[32] ? 33'(-dx) : 33'(dx);
      s1_dy_q <= dy[32] ? 33'(-dy) : 33'(dy);
      s1_dz_q <= dz[32] ? 33'(-dz) : 33'(dz);
      s1_ctx_q.h16 <= item.data.type_hash[31:16] ^ item.data.type_hash[15:0];
      s1_ctx_q.item_key     <= item.data.item_key;
      s1_ctx_q.depth_offset <= item.data.depth_offset;
      s1_ctx_q.mode <= mode_q;
      s1_ctx_q.far  <= far_q;
    end
  end

  // Stage 2: squares, one multiplier each.
  logic        s2_vld_q;
  logic [65:0] s2_x_q, s2_y_q, s2_z_q;
  rskg_pkg::ctx_t s2_ctx_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_vld_q <= 1'b0;
    else if (adv) s2_vld_q <= s1_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_x_q <= s1_dx_q * s1_dx_q;
      s2_y_q <= s1_dy_q * s1_dy_q;
      s2_z_q <= s1_dz_q * s1_dz_q;
      s2_ctx_q <= s1_ctx_q;
    end
  end

  // Root cells, most significant bit first; the sum feeds the first cell.
  rskg_pkg::sqrt_t sq [SB+1];
  always_comb begin
    sq[0].vld  = s2_vld_q;
    sq[0].rem  = QW'(s2_x_q) + QW'(s2_y_q) + QW'(s2_z_q);
    sq[0].root = '0;
    sq[0].ctx  = s2_ctx_q;
  end

  for (genvar g = 0; g < SB; g++) begin : g_sqrt
    rskg_sqrt_cell #(.Bit(SB - 1 - g)) u_cell (
      .clk_i (clk_i), .rst_ni (rst_ni), .en_i (adv),
      .in_i  (sq[g]), .out_o (sq[g+1])
    );
  end

  // Stage: distance, range checks, numerator d * M.
  rskg_pkg::sqrt_t sr;
  assign sr = sq[SB];
  logic signed [35:0] tot_d;
  logic [31:0] dpos;
  logic [31:0] maxv;
  logic        pos, sat;
  logic        m32;
  always_comb begin
    m32 = (sr.ctx.mode == rskg_pkg::ModeDepthOnly);
    if (m32) tot_d = 36'($signed({1'b0, sr.ctx.far[30:1]})) + 36'(sr.ctx.depth_offset);
    else     tot_d = 36'($signed({1'b0, sr.root})) + 36'(sr.ctx.depth_offset);
    pos  = !tot_d[35] && (tot_d != '0);
    sat  = pos && (tot_d[34:0] >= 35'(sr.ctx.far));
    dpos = tot_d[31:0];
    maxv = m32 ? 32'hFFFF_FFFF : 32'h0000_FFFF;
  end

  logic           n_vld_q;
  logic [31:0]    n_d_q, n_m_q;
  logic [1:0]     n_sat_q;
  rskg_pkg::ctx_t n_ctx_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) n_vld_q <= 1'b0;
    else if (adv) n_vld_q <= sr.vld;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      n_d_q   <= dpos;
      n_m_q   <= maxv;
      n_sat_q <= !pos ? rskg_pkg::SatZero : (sat ? rskg_pkg::SatMax : rskg_pkg::SatNone);
      n_ctx_q <= sr.ctx;
    end
  end

  // Divider cells, quotient msb first.
  rskg_pkg::div_t dv [rskg_pkg::DivBits+1];
  logic [63:0] prod;
  assign prod = n_d_q * n_m_q;

  // The first 32 numerator bits stay below far (d < far, M < 2^32): skip them.
  always_comb begin
    dv[0].vld = n_vld_q;
    dv[0].rem = prod[63:32];
    dv[0].num = {prod[31:0], 32'h0};
    dv[0].quo = '0;
    dv[0].sat = n_sat_q;
    dv[0].ctx = n_ctx_q;
  end

  for (genvar g = 0; g < rskg_pkg::DivBits; g++) begin : g_div
    rskg_div_cell u_cell (
      .clk_i (clk_i), .rst_ni (rst_ni), .en_i (adv),
      .in_i  (dv[g]), .out_o (dv[g+1])
    );
  end

  // Packing and output register.
  rskg_pkg::div_t df;
  logic [31:0] nq;
  logic [63:0] packed_key;
  assign df = dv[rskg_pkg::DivBits];
  always_comb begin
    case (df.sat)
      rskg_pkg::SatZero: nq = '0;
      rskg_pkg::SatMax:
        nq = (df.ctx.mode == rskg_pkg::ModeDepthOnly) ? 32'hFFFF_FFFF : 32'h0000_FFFF;
      default: nq = df.quo;
    endcase
    case (df.ctx.mode)
      rskg_pkg::ModeTypeKeyDist:
        packed_key = {df.ctx.h16, df.ctx.item_key, nq[15:0]};
      rskg_pkg::ModeBackToFront:
        packed_key = {16'hFFFF - nq[15:0], df.ctx.h16, df.ctx.item_key};
      rskg_pkg::ModeDepthOnly:
        packed_key = {32'h0, 32'hFFFF_FFFF - nq};
      default:
        packed_key = {32'h0, df.ctx.item_key};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (adv) out_vld_q <= df.vld;
  end
  always_ff @(posedge clk_i) begin
    if (adv) out_key_q <= packed_key;
  end

  assign key.valid    = out_vld_q;
  assign key.sort_key = out_key_q;

`ifndef SYNTHESIS
  // A stalled output must hold its key.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !key.ready |=> out_vld_q && $stable(out_key_q))
    else $error("output changed while stalled");
  // Input ready follows the output register state.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item.ready == (!out_vld_q || key.ready))
    else $error("input ready mismatch");
  // The root remainder never exceeds twice the root, so the root is the integer floor.
  a_sqrt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sr.vld |-> (sr.rem <= (QW'(sr.root) << 1)))
    else $error("square root remainder out of range");
`endif
endmodule

[test/tb_top.sv]
// Self-checking testbench of the draw-call sort key generator.
module tb_top;

  logic clk_i;
  logic rst_ni;

  rskg_cfg_if  cfg_ch ();
  rskg_item_if item_ch ();
  rskg_key_if  key_ch ();

  render_sort_key_generator_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg    (cfg_ch.sink),
    .item   (item_ch.sink),
    .key    (key_ch.source)
  );

  // Shadow copy of the configuration registers.
  logic [1:0]         mode_q;
  logic signed [31:0] cam_x_q, cam_y_q, cam_z_q;
  logic [30:0]        far_q;

  logic [63:0] key_queue[$];
  int          mismatches;
  int          keys_seen;
  int          items_sent;
  bit          quiet_end;

  // Directed stimulus rows; known is set where the key is typed in.
  typedef struct {
    rskg_pkg::item_t it;
    bit              known;
    logic [63:0]     key;
  } row_t;

  // Integer square root floor of a 68-bit sum of squares.
  function automatic logic [33:0] root_of(input logic [67:0] sq);
    logic [33:0] r;
    logic [33:0] c;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      c = r | (34'd1 << b);
      if ({68'd0, c} * {68'd0, c} <= {68'd0, sq}) r = c;
    end
    return r;
  endfunction

  // Scales a distance to maxv against the far plane, saturating at both ends.
  function automatic logic [31:0] scaled_dist(input logic signed [35:0] d,
                                              input logic [31:0] maxv);
    logic [95:0] p;
    if (d <= 0) return '0;
    if ($unsigned(d) >= {5'd0, far_q}) return maxv;
    p = {60'd0, $unsigned(d)} * {64'd0, maxv};
    return 32'(p / {65'd0, far_q});
  endfunction

  function automatic logic [15:0] near16(input rskg_pkg::item_t it);
    logic signed [32:0] dx, dy, dz;
    logic signed [67:0] wx, wy, wz;
    logic [67:0] sq;
    logic [33:0] len;
    dx = 33'(cam_x_q) - 33'(it.object_x);
    dy = 33'(cam_y_q) - 33'(it.object_y);
    dz = 33'(cam_z_q) - 33'(it.object_z);
    wx = 68'(dx);
    wy = 68'(dy);
    wz = 68'(dz);
    sq = wx * wx + wy * wy + wz * wz;
    len = root_of(sq);
    return 16'(scaled_dist($signed({2'b00, len}) + 36'(it.depth_offset), 32'hFFFF));
  endfunction

  // Computes the sort key of one draw item under the current settings.
  function automatic logic [63:0] sort_key_of(input rskg_pkg::item_t it);
    logic [15:0] h16;
    h16 = it.type_hash[31:16] ^ it.type_hash[15:0];
    case (mode_q)
      rskg_pkg::ModeTypeKeyDist: return {h16, it.item_key, near16(it)};
      rskg_pkg::ModeBackToFront: return {16'hFFFF - near16(it), h16, it.item_key};
      rskg_pkg::ModeDepthOnly: return {32'd0, 32'hFFFFFFFF -
          scaled_dist(36'(far_q >> 1) + 36'(it.depth_offset), 32'hFFFFFFFF)};
      default: return {32'd0, it.item_key};
    endcase
  endfunction

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Random idle bursts before a transaction; valid drops for the burst.
  task automatic idle_burst();
    int n;
    if (!quiet_end && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 6);
      item_ch.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Writes one configuration register and updates the shadow copy.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_ch.index <= idx;
    cfg_ch.wdata <= val;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
    case (idx)
      rskg_pkg::RegSortMode: mode_q = val[1:0];
      rskg_pkg::RegCameraX:  cam_x_q = val;
      rskg_pkg::RegCameraY:  cam_y_q = val;
      rskg_pkg::RegCameraZ:  cam_z_q = val;
      rskg_pkg::RegFarPlane: far_q = val[30:0];
      default: ;
    endcase
  endtask

  // Sends one item and queues its expected key.
  task automatic send_item(input rskg_pkg::item_t it);
    idle_burst();
    item_ch.data  <= it;
    item_ch.valid <= 1'b1;
    key_queue.push_back(sort_key_of(it));
    do @(posedge clk_i); while (!item_ch.ready);
    items_sent++;
  endtask

  // Waits until every key has come back, then lets the pipeline settle.
  task automatic drain();
    item_ch.valid <= 1'b0;
    while (key_queue.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic rskg_pkg::item_t rand_item(input bit near_cam);
    rskg_pkg::item_t it;
    it.type_hash = $urandom();
    it.item_key  = $urandom();
    if (near_cam) begin
      it.object_x = cam_x_q + $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
      it.object_y = cam_y_q + $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
      it.object_z = cam_z_q + $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
      it.depth_offset = $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
    end else begin
      it.object_x = $urandom();
      it.object_y = $urandom();
      it.object_z = $urandom();
      it.depth_offset = $urandom();
    end
    return it;
  endfunction

  // Output side: random stall bursts, compare against the oldest expectation.
  initial begin
    logic [63:0] exp_key;
    key_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!quiet_end && $urandom_range(0, 3) == 0) begin
        key_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      key_ch.ready <= 1'b1;
      @(posedge clk_i);
      if (key_ch.valid && key_ch.ready) begin
        keys_seen++;
        if (key_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected key %h", key_ch.sort_key);
        end else begin
          exp_key = key_queue.pop_front();
          if (exp_key !== key_ch.sort_key) begin
            mismatches++;
            if (mismatches <= 10)
              $display("key mismatch: expected %h actual %h", exp_key, key_ch.sort_key);
          end
        end
      end
    end
  end

  // Stimulus.
  initial begin
    row_t rows[$];
    row_t r;
    logic [31:0] far_set[4];
    mismatches = 0;
    keys_seen = 0;
    items_sent = 0;
    quiet_end = 1'b0;
    rst_ni = 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= rskg_pkg::RegSortMode;
    cfg_ch.wdata <= '0;
    item_ch.valid <= 1'b0;
    item_ch.data <= '0;
    mode_q = rskg_pkg::ModeTypeKeyDist;
    cam_x_q = '0;
    cam_y_q = '0;
    cam_z_q = '0;
    far_q = 31'd65536;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows after reset: object at camera, zero offset gives distance zero.
    r.it = '0; r.known = 1; r.key = 64'd0; rows.push_back(r);
    r.it = '0; r.it.type_hash = 32'hFFFF0000; r.it.item_key = 32'hFFFFFFFF;
    r.key = {16'hFFFF, 32'hFFFFFFFF, 16'd0}; rows.push_back(r);
    // Distance at or beyond the far plane saturates.
    r.it = '0; r.it.object_x = 32'sh10000; r.key = {48'd0, 16'hFFFF}; rows.push_back(r);
    r.it = '0; r.it.depth_offset = 32'sh7FFFFFFF; r.key = {48'd0, 16'hFFFF};
    rows.push_back(r);
    // Negative total distance clamps to zero.
    r.it = '0; r.it.object_x = 32'sh100; r.it.depth_offset = 32'sh80000000;
    r.key = 64'd0; rows.push_back(r);
    // Extreme positions, checked by the predictor.
    r.known = 0;
    r.it = '0; r.it.object_x = 32'sh80000000; r.it.object_y = 32'sh80000000;
    r.it.object_z = 32'sh80000000; rows.push_back(r);
    r.it = '0; r.it.object_x = 32'sh7FFFFFFF; r.it.object_y = 32'sh80000000;
    r.it.object_z = 32'sh7FFFFFFF; r.it.depth_offset = 32'sh80000000; rows.push_back(r);
    r.it = '0; r.it.object_x = 32'sh8000; r.it.type_hash = 32'h1234ABCD; rows.push_back(r);
    foreach (rows[i]) begin
      if (rows[i].known && rows[i].key !== sort_key_of(rows[i].it)) begin
        mismatches++;
        if (mismatches <= 10) $display("directed row %0d disagrees with predictor", i);
      end
      send_item(rows[i].it);
    end
    drain();

    // Each mode with camera extremes and far plane extremes.
    far_set = '{32'd1, 32'h7FFFFFFF, 32'd65536, 32'd3};
    for (int m = 0; m < 4; m++) begin
      write_reg(rskg_pkg::RegSortMode, 32'(m));
      write_reg(rskg_pkg::RegCameraX, m[0] ? 32'h7FFFFFFF : 32'h80000000);
      write_reg(rskg_pkg::RegCameraY, 32'h0);
      write_reg(rskg_pkg::RegCameraZ, m[1] ? 32'h80000000 : 32'h12345);
      write_reg(rskg_pkg::RegFarPlane, far_set[m]);
      for (int k = 0; k < 4; k++) send_item(rand_item(k[0]));
      drain();
    end

    // Random phases, each with fresh random settings.
    for (int ph = 0; ph < 16; ph++) begin
      if (ph == 13) quiet_end = 1'b1;
      write_reg(rskg_pkg::RegSortMode, 32'($urandom_range(0, 3)));
      write_reg(rskg_pkg::RegCameraX, $urandom());
      write_reg(rskg_pkg::RegCameraY, $urandom());
      write_reg(rskg_pkg::RegCameraZ, $urandom());
      case ($urandom_range(0, 3))
        0: write_reg(rskg_pkg::RegFarPlane, 32'($urandom_range(1, 16)));
        1: write_reg(rskg_pkg::RegFarPlane, $urandom() >> 1);
        default: write_reg(rskg_pkg::RegFarPlane, 32'($urandom_range(32'h4000, 32'h400000)));
      endcase
      for (int k = 0; k < 50; k++) send_item(rand_item($urandom_range(0, 3) != 0));
      drain();
    end

    $display("Sent %0d draw items and checked %0d sort keys across all four modes,",
             items_sent, keys_seen);
    $display("with camera and far plane settings including their extremes.");
    if (mismatches == 0 && key_queue.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Timeout.
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
